// ===== rtl/tftp_read_receiver_core_macros.svh =====
// ----------------------------------------------------------------------------
// tftp_read_receiver_core_macros.svh
// Assertion helpers shared by the tftp read receiver rtl
// ----------------------------------------------------------------------------
`ifndef TFTP_READ_RECEIVER_CORE_MACROS_SVH
`define TFTP_READ_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TFTP_RR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tftp_rr same-cycle check failed");

// next-cycle implication, checked outside reset
`define TFTP_RR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tftp_rr next-cycle check failed");

`endif

// ===== rtl/tftp_rr_pkg.sv =====
// ----------------------------------------------------------------------------
// tftp_rr_pkg
// Types, codes and constants of the tftp read receiver
// ----------------------------------------------------------------------------
package tftp_rr_pkg;

	// command codes on the input stream
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [1:0] REG_BASE_ADDRESS = 2'd1;
	localparam logic [1:0] REG_TIMEOUT      = 2'd2;

	// configuration reset values
	localparam logic [15:0] BLOCK_SIZE_RST = 16'd1468;
	localparam logic [31:0] BASE_ADDR_RST  = 32'd0;
	localparam logic [23:0] TIMEOUT_RST    = 24'h050000;

	// transfer phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_REQ  = 2'd1;
	localparam logic [1:0] PH_RECV = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// packet opcodes
	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ERROR = 16'd5;
	localparam logic [15:0] OP_OACK  = 16'd6;

	// server error codes and their reported form
	localparam logic [15:0] SRV_ERR_NOT_FOUND = 16'd1;
	localparam logic [15:0] SRV_ERR_BAD_OP    = 16'd4;
	localparam logic [15:0] SRV_ERR_BAD_TID   = 16'd5;
	localparam logic [1:0]  ERR_NOT_FOUND     = 2'd0;
	localparam logic [1:0]  ERR_BAD_OP        = 2'd1;
	localparam logic [1:0]  ERR_BAD_TID       = 2'd2;
	localparam logic [1:0]  ERR_OTHER         = 2'd3;

	// header length and byte position limit
	localparam int unsigned   HDR_LEN = 4;
	localparam logic [16:0]   POS_MAX = 17'h1FFFF;

	localparam int unsigned OUT_TDATA_W = 96;

	typedef struct packed {
		logic [15:0] block_size;
		logic [31:0] base_address;
		logic [23:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	// member order gives the tdata layout, last member in the lowest bits
	typedef struct packed {
		logic [31:0] total_bytes;
		logic        done_res;
		logic [1:0]  error_code;
		logic        error_valid;
		logic        request_valid;
		logic [15:0] ack_block;
		logic        ack_valid;
		logic [7:0]  write_data;
		logic [31:0] write_address;
		logic        write_valid;
	} result_t;

	function automatic logic [1:0] map_error(input logic [15:0] code);
		logic [1:0] r;
		priority if (code == SRV_ERR_NOT_FOUND) r = ERR_NOT_FOUND;
		else if (code == SRV_ERR_BAD_OP) r = ERR_BAD_OP;
		else if (code == SRV_ERR_BAD_TID) r = ERR_BAD_TID;
		else r = ERR_OTHER;
		return r;
	endfunction

endpackage

// ===== rtl/tftp_rr_cfg.sv =====
// ----------------------------------------------------------------------------
// tftp_rr_cfg
// Configuration registers written through a plain write port
// ----------------------------------------------------------------------------
module tftp_rr_cfg
	import tftp_rr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size    <= BLOCK_SIZE_RST;
			cfg_q.base_address  <= BASE_ADDR_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLOCK_SIZE:   cfg_q.block_size    <= cfg_wdata[15:0];
				REG_BASE_ADDRESS: cfg_q.base_address  <= cfg_wdata;
				REG_TIMEOUT:      cfg_q.timeout_ticks <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tftp_rr_engine.sv =====
// ----------------------------------------------------------------------------
// tftp_rr_engine
// Transfer state and per-beat packet parsing, one beat per clock while fire is high
// ----------------------------------------------------------------------------
module tftp_rr_engine
	import tftp_rr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  beat_t   beat,
	input  cfg_t    cfg,
	output result_t res
);

	logic [1:0]  phase_q, phase_d;
	logic [16:0] pos_q, pos_d;
	logic [15:0] opcode_q, opcode_d;
	logic [15:0] word_q, word_d;
	logic [15:0] exp_blk_q, exp_blk_d;
	logic [31:0] addr_q, addr_d;
	logic [31:0] total_q, total_d;
	logic [23:0] tick_q, tick_d;

	logic [23:0] tick_inc;
	logic [16:0] len;
	logic [17:0] full_len;
	logic        match_cur;
	logic        match_new;
	logic        active;

	assign tick_inc  = tick_q + 24'd1;
	assign len       = (pos_q < POS_MAX) ? pos_q + 17'd1 : POS_MAX;
	assign full_len  = {2'b00, cfg.block_size} + 18'(HDR_LEN);
	assign match_cur = (opcode_q == OP_DATA) && (word_q == exp_blk_q);
	assign match_new = (opcode_d == OP_DATA) && (word_d == exp_blk_q);
	assign active    = (phase_q == PH_REQ) || (phase_q == PH_RECV);

	// header capture, used both by the write decision and the packet end
	always_comb begin
		opcode_d = opcode_q;
		word_d   = word_q;
		if (beat.cmd == CMD_START) begin
			opcode_d = '0;
			word_d   = '0;
		end else if (beat.cmd == CMD_BYTE && active) begin
			priority if (pos_q == 17'd0) opcode_d = {beat.data_byte, 8'h00};
			else if (pos_q == 17'd1) opcode_d = {opcode_q[15:8], beat.data_byte};
			else if (pos_q == 17'd2) word_d = {beat.data_byte, 8'h00};
			else if (pos_q == 17'd3) word_d = {word_q[15:8], beat.data_byte};
			else ;
		end
	end

	// next state and result of one beat
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		exp_blk_d = exp_blk_q;
		addr_d    = addr_q;
		total_d   = total_q;
		tick_d    = tick_q;
		res       = '0;

		unique case (beat.cmd)
			CMD_START: begin
				phase_d           = PH_REQ;
				pos_d             = '0;
				exp_blk_d         = 16'd1;
				addr_d            = cfg.base_address;
				total_d           = '0;
				tick_d            = '0;
				res.request_valid = 1'b1;
			end
			CMD_TICK: begin
				if (phase_q == PH_REQ) begin
					if (tick_inc >= cfg.timeout_ticks) begin
						res.request_valid = 1'b1;
						tick_d            = '0;
					end else begin
						tick_d = tick_inc;
					end
				end
			end
			CMD_BYTE: begin
				if (active) begin
					// payload byte past the header of the expected block
					if (pos_q >= 17'(HDR_LEN) && match_cur) begin
						res.write_valid   = 1'b1;
						res.write_address = addr_q;
						res.write_data    = beat.data_byte;
						addr_d            = addr_q + 32'd1;
						total_d           = total_q + 32'd1;
					end
					// packet end: judge and answer
					if (beat.last_byte) begin
						phase_d = PH_RECV;
						tick_d  = '0;
						pos_d   = '0;
						if (len >= 17'(HDR_LEN)) begin
							priority if (match_new) begin
								res.ack_valid = 1'b1;
								res.ack_block = exp_blk_q;
								if ({1'b0, len} < full_len) begin
									res.done_res = 1'b1;
									phase_d      = PH_DONE;
								end else begin
									exp_blk_d = exp_blk_q + 16'd1;
								end
							end else if (opcode_d == OP_ERROR) begin
								res.error_valid = 1'b1;
								res.error_code  = map_error(word_d);
							end else if (opcode_d == OP_OACK) begin
								res.ack_valid = 1'b1;
								res.ack_block = '0;
							end else ;
						end
					end else begin
						pos_d = len;
					end
				end
			end
			default: ;
		endcase

		res.total_bytes = total_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			opcode_q  <= '0;
			word_q    <= '0;
			exp_blk_q <= 16'd1;
			addr_q    <= '0;
			total_q   <= '0;
			tick_q    <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			opcode_q  <= opcode_d;
			word_q    <= word_d;
			exp_blk_q <= exp_blk_d;
			addr_q    <= addr_d;
			total_q   <= total_d;
			tick_q    <= tick_d;
		end
	end

endmodule

// ===== rtl/tftp_read_receiver_core.sv =====
// ----------------------------------------------------------------------------
// tftp_read_receiver_core
// Receiving side of a tftp read transfer with beat streams in and out
// ----------------------------------------------------------------------------
// Each input beat carries a command in tuser (start, payload byte, timer tick)
// and yields exactly one result beat. The block takes one beat per clock while
// the result stream is not stalled. A beat passes the input register, where it is
// accepted, then the result register, from which it is presented on the result
// stream; the state update and parsing for a beat sit between the two registers.
// With the result register full and stalled, one more input beat is still taken
// into the input register. The user must write configuration only while no beat
// is in flight; the block itself does not enforce it.
module tftp_read_receiver_core
	import tftp_rr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [31:0]            cfg_wdata,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] data_byte
	input  logic [1:0]             s_tuser,   // [1:0] cmd
	input  logic                   s_tlast,   // last_byte
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] write_valid, [32:1] write_address, [40:33] write_data,
	// [41] ack_valid, [57:42] ack_block, [58] request_valid,
	// [59] error_valid, [61:60] error_code, [62] done_res,
	// [94:63] total_bytes, [95] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	cfg_t    cfg;
	beat_t   beat_s1;
	logic    v_s1;
	result_t res;
	result_t res_q;
	logic    out_v_q;
	logic    advance;

	tftp_rr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// beat moves from the input register to the result register
	assign advance  = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || advance;

	tftp_rr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.beat   (beat_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1 <= '{cmd: s_tuser, data_byte: s_tdata, last_byte: s_tlast};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, res_q};

	// checks on the receiver's own logic
	`include "tftp_read_receiver_core_macros.svh"

	`TFTP_RR_ASSERT_SAME(a_done_acks, out_v_q && res_q.done_res, res_q.ack_valid)
	`TFTP_RR_ASSERT_SAME(a_err_no_ack, out_v_q && res_q.error_valid, !res_q.ack_valid)
	`TFTP_RR_ASSERT_SAME(a_req_no_write, out_v_q && res_q.request_valid, !res_q.write_valid)
	`TFTP_RR_ASSERT_NEXT(a_stall_holds_s1, v_s1 && out_v_q && !m_tready, v_s1)

endmodule
